### rtl/tcrl_pkg.sv
// ----------------------------------------------------------------------------
// tcrl_pkg
// Shared types, codes and saturating helpers for the tenant classifier,
// rate limiter and worker balancer.
// ----------------------------------------------------------------------------
package tcrl_pkg;

  localparam logic       KIND_PACKET    = 1'b0;
  localparam logic       KIND_RULE      = 1'b1;
  localparam logic [7:0] PROTO_TCP      = 8'd6;
  localparam logic [7:0] PROTO_UDP      = 8'd17;
  localparam logic       CFG_RATE_LIMIT = 1'b0;
  localparam logic       CFG_CAPACITY   = 1'b1;
  localparam logic [31:0] RATE_LIMIT_RST = 32'd2000000;
  localparam logic [31:0] CAPACITY_RST   = 32'd10000000;
  localparam logic [31:0] ALL_ONES       = 32'hffffffff;

  typedef struct packed {
    logic        kind;
    logic [2:0]  rule_index;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    logic [7:0]  proto;
    logic [3:0]  rule_tenant;
    logic [31:0] time_slot;
  } tcrl_in_t;

  typedef struct packed {
    logic [3:0] tenant;
    logic [1:0] worker;
    logic       dropped;
  } tcrl_out_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [3:0]  owner;
  } tcrl_rule_t;

  typedef struct packed {
    logic [31:0] slot;
    logic [31:0] cur;
    logic [31:0] prev;
  } tcrl_wrk_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == ALL_ONES) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] sat_dec(input logic [31:0] v);
    return (v == 32'd0) ? v : v - 32'd1;
  endfunction

endpackage

### rtl/tcrl_if.sv
// ----------------------------------------------------------------------------
// tcrl_in_if / tcrl_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tcrl_in_if import tcrl_pkg::*; ();
  logic     valid;
  logic     ready;
  tcrl_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcrl_out_if import tcrl_pkg::*; ();
  logic      valid;
  logic      ready;
  tcrl_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tcrl_match.sv
// ----------------------------------------------------------------------------
// tcrl_match
// Classifier rule table and first-match lookup of a packet's 5-tuple.
// ----------------------------------------------------------------------------
module tcrl_match import tcrl_pkg::*; #(
  parameter int RULES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  tcrl_in_t   key,
  output logic [3:0] tenant
);

  tcrl_rule_t rules_r [RULES];
  logic [RULES-1:0] hit;
  logic [15:0] sp, dp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < RULES; r++) rules_r[r] <= '0;
    end else if (wr_en) begin
      for (int r = 0; r < RULES; r++) begin
        if (int'(key.rule_index) == r) begin
          rules_r[r] <= '{src: key.ip_src, dst: key.ip_dst, sport: key.l4_src,
                          dport: key.l4_dst, proto: key.proto,
                          owner: key.rule_tenant};
        end
      end
    end
  end

  // ports only count for tcp and udp
  always_comb begin
    if (key.proto == PROTO_TCP || key.proto == PROTO_UDP) begin
      sp = key.l4_src;
      dp = key.l4_dst;
    end else begin
      sp = '0;
      dp = '0;
    end
  end

  always_comb begin
    for (int r = 0; r < RULES; r++) begin
      hit[r] = rules_r[r].src == key.ip_src && rules_r[r].dst == key.ip_dst &&
               rules_r[r].sport == sp && rules_r[r].dport == dp &&
               rules_r[r].proto == key.proto;
    end
  end

  // lowest index wins
  always_comb begin
    tenant = '0;
    for (int r = RULES - 1; r >= 0; r--) begin
      if (hit[r]) tenant = rules_r[r].owner;
    end
  end

endmodule

### rtl/tenant_classify_rate_limit_balance_unit.sv
// ----------------------------------------------------------------------------
// tenant_classify_rate_limit_balance_unit
// Classifies packets to tenants, rate-limits per tenant and time slot, and
// rebalances overloaded tenants onto the least-loaded worker.
// ----------------------------------------------------------------------------
// A rule write is taken in the idle state and stores its rule. A packet passes
// rule match and tenant memory read, worker memory read, then the write-back
// and result. On a tenant's first packet in a slot whose worker is
// overloaded, a scan of the worker memory (one entry per cycle through its
// single read port) and a move step come before the write-back. A
// new item is taken only once the previous one has written back; a result
// waits in the output register, and the next packet is taken and worked on
// but holds at its write-back until that result has been accepted.
// ----------------------------------------------------------------------------
module tenant_classify_rate_limit_balance_unit import tcrl_pkg::*; #(
  parameter int RULES   = 8,
  parameter int TENANTS = 16,
  parameter int WORKERS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  tcrl_in_if.sink     in_ch,
  tcrl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int TW = $clog2(TENANTS);
  localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEN  = 3'd1;
  localparam logic [2:0] S_WRK  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  typedef struct packed {
    logic [31:0]   slot;
    logic [31:0]   count;
    logic [WW-1:0] worker;
  } ten_t;

  function automatic logic [WW-1:0] rst_worker(input logic [TW-1:0] t);
    return (int'(t) < WORKERS && int'(t) < 4) ? WW'(t) : '0;
  endfunction

  logic [2:0]  state_r;
  logic [31:0] limit_r, cap_r;
  logic        out_valid_r;
  tcrl_out_t   out_data_r;

  logic [3:0]    match_tid, tid_map;
  logic [TW-1:0] tidx;
  logic          in_acc;

  logic [31:0]   ts_r, cnt_r;
  logic [3:0]    tid_r;
  logic [TW-1:0] tidx_r;
  logic [WW-1:0] tw_r, k_r, minq_r;
  logic          first_r, dropped_r, move_r;
  logic [31:0]   wslot_r, wcur_r, wprev_r;
  logic [31:0]   min_r, minslot_r, mincur_r;

  // tenant memory
  ten_t               ten_mem [TENANTS];
  logic [TENANTS-1:0] ten_vld_r;
  ten_t               ten_rd_r, ten_ent, ten_wdata;
  logic               ten_rd_vld_r, ten_we;

  // worker memory
  tcrl_wrk_t          wrk_mem [WORKERS];
  logic [WORKERS-1:0] wrk_vld_r;
  tcrl_wrk_t          wrk_rd_r, wrk_ent, wrk_roll, scan_val, wrk_wdata;
  logic               wrk_rd_vld_r, wrk_we;
  logic [WW-1:0]      wrk_raddr, wrk_waddr;

  logic        first_n, drop_n, over_n, move_n, fin_go;
  logic [31:0] cnt_n, minload;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  tcrl_match #(.RULES(RULES)) u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc && in_ch.data.kind == KIND_RULE),
    .key    (in_ch.data),
    .tenant (match_tid)
  );

  assign tid_map = (int'(match_tid) >= TENANTS) ? 4'd0 : match_tid;
  assign tidx    = TW'(tid_map);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RATE_LIMIT_RST;
      cap_r   <= CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE_LIMIT: limit_r <= cfg_wdata;
        CFG_CAPACITY:   cap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tenant entry, falling back to its reset value until first written
  always_comb begin
    if (ten_rd_vld_r) ten_ent = ten_rd_r;
    else ten_ent = '{slot: '0, count: '0, worker: rst_worker(tidx_r)};
    first_n = (ts_r != ten_ent.slot);
    cnt_n   = first_n ? 32'd1 : sat_inc(ten_ent.count);
    drop_n  = !first_n && (cnt_n > limit_r);
  end

  always_comb begin
    wrk_ent  = wrk_rd_vld_r ? wrk_rd_r : '0;
    wrk_roll = wrk_ent;
    if (first_r && ts_r != wrk_ent.slot) begin
      wrk_roll.slot = ts_r;
      wrk_roll.prev = wrk_ent.cur;
      wrk_roll.cur  = '0;
    end
    over_n   = first_r && (wrk_roll.prev >= cap_r);
    // the tenant's own worker is not yet written back
    scan_val = (k_r == tw_r) ? '{slot: wslot_r, cur: wcur_r, prev: wprev_r} : wrk_ent;
    minload  = sat_inc(min_r);
    move_n   = minload < cap_r;
    fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    unique case (state_r)
      S_TEN:   wrk_raddr = ten_ent.worker;
      S_SCAN:  wrk_raddr = WW'(k_r + 1'b1);
      default: wrk_raddr = '0;
    endcase
  end

  always_comb begin
    wrk_we    = 1'b0;
    wrk_waddr = tw_r;
    wrk_wdata = '{slot: wslot_r, cur: sat_inc(wcur_r),
                  prev: (move_r && minq_r != tw_r) ? sat_dec(wprev_r) : wprev_r};
    if (state_r == S_MOVE && move_n && minq_r != tw_r) begin
      wrk_we    = 1'b1;
      wrk_waddr = minq_r;
      wrk_wdata = '{slot: minslot_r, cur: mincur_r, prev: minload};
    end else if (fin_go) begin
      wrk_we = 1'b1;
    end
    ten_we    = fin_go;
    ten_wdata = '{slot: ts_r, count: cnt_r, worker: move_r ? minq_r : tw_r};
  end

  always_ff @(posedge clk) begin
    ten_rd_r <= ten_mem[tidx];
    if (ten_we) ten_mem[tidx_r] <= ten_wdata;
    wrk_rd_r <= wrk_mem[wrk_raddr];
    if (wrk_we) wrk_mem[wrk_waddr] <= wrk_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_vld_r    <= '0;
      wrk_vld_r    <= '0;
      ten_rd_vld_r <= 1'b0;
      wrk_rd_vld_r <= 1'b0;
    end else begin
      ten_rd_vld_r <= ten_vld_r[tidx];
      wrk_rd_vld_r <= wrk_vld_r[wrk_raddr];
      if (ten_we) ten_vld_r[tidx_r] <= 1'b1;
      if (wrk_we) wrk_vld_r[wrk_waddr] <= 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_go || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: if (in_acc && in_ch.data.kind == KIND_PACKET) state_r <= S_TEN;
        S_TEN:  state_r <= S_WRK;
        S_WRK:  state_r <= over_n ? S_SCAN : S_FIN;
        S_SCAN: if (k_r == WW'(WORKERS - 1)) state_r <= S_MOVE;
        S_MOVE: state_r <= S_FIN;
        S_FIN:  if (fin_go) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ts_r   <= in_ch.data.time_slot;
        tid_r  <= tid_map;
        tidx_r <= tidx;
      end
      S_TEN: begin
        tw_r      <= ten_ent.worker;
        first_r   <= first_n;
        cnt_r     <= cnt_n;
        dropped_r <= drop_n;
        move_r    <= 1'b0;
      end
      S_WRK: begin
        wslot_r <= wrk_roll.slot;
        wcur_r  <= wrk_roll.cur;
        wprev_r <= wrk_roll.prev;
        k_r     <= '0;
        min_r   <= ALL_ONES;
        minq_r  <= '0;
      end
      S_SCAN: begin
        if (min_r > scan_val.prev) begin
          min_r     <= scan_val.prev;
          minq_r    <= k_r;
          minslot_r <= scan_val.slot;
          mincur_r  <= scan_val.cur;
        end
        k_r <= WW'(k_r + 1'b1);
      end
      S_MOVE: move_r <= move_n;
      S_FIN: begin
        if (fin_go) begin
          out_data_r <= '{tenant: tid_r, worker: 2'(tw_r), dropped: dropped_r};
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside write-back");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> int'(k_r) < WORKERS)
    else $error("worker scan ran past last worker");

  a_packet_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.data.kind == KIND_PACKET) |=> state_r == S_TEN)
    else $error("packet item did not start lookup");

  a_move_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> $past(state_r) == S_SCAN)
    else $error("move without a completed scan");
`endif

endmodule

### test/tenant_classify_rate_limit_balance_unit_tb.sv
// ----------------------------------------------------------------------------
// tenant_classify_rate_limit_balance_unit_tb
// Drives rule writes and packets through the tenant classifier, rate limiter
// and worker balancer, predicts tenant, worker and drop flag for every
// packet, and compares each result against that prediction.
// ----------------------------------------------------------------------------
module tenant_classify_rate_limit_balance_unit_tb;
  import tcrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRULE = 8;
  localparam int NTEN = 16;
  localparam int NWRK = 4;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_RATE_LIMIT;
  logic [31:0] cfg_wdata = '0;

  tcrl_in_if in_ch ();
  tcrl_out_if out_ch ();

  tenant_classify_rate_limit_balance_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] rate_limit, capacity;
  tcrl_rule_t  rules [NRULE];
  logic [31:0] ten_slot [NTEN];
  logic [31:0] ten_cnt [NTEN];
  logic [1:0]  ten_wrk [NTEN];
  logic [31:0] wrk_slot [NWRK];
  logic [31:0] wrk_cur [NWRK];
  logic [31:0] wrk_prev [NWRK];

  tcrl_out_t expected_results [$];
  int errors = 0;
  int packets_sent = 0, rules_sent = 0, results_seen = 0, drops_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [31:0] cur_slot = 32'd5;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    return (a > ALL_ONES - b) ? ALL_ONES : a + b;
  endfunction

  task automatic reset_predictor();
    rate_limit = RATE_LIMIT_RST;
    capacity = CAPACITY_RST;
    for (int i = 0; i < NRULE; i++) rules[i] = '0;
    for (int t = 0; t < NTEN; t++) begin
      ten_slot[t] = '0;
      ten_cnt[t] = '0;
      ten_wrk[t] = (t < NWRK) ? 2'(t) : 2'd0;
    end
    for (int w = 0; w < NWRK; w++) begin
      wrk_slot[w] = '0;
      wrk_cur[w] = '0;
      wrk_prev[w] = '0;
    end
  endtask

  task automatic predict_dispatch(input tcrl_in_t it);
    logic [15:0] sp, dp;
    logic [3:0] tid;
    logic [1:0] wid, min_q;
    logic [31:0] best_load;
    logic drop;
    tcrl_out_t r;
    tid = '0;
    drop = 1'b0;
    if (it.kind == KIND_RULE) begin
      rules[it.rule_index] = '{it.ip_src, it.ip_dst, it.l4_src, it.l4_dst,
                               it.proto, it.rule_tenant};
      return;
    end
    sp = it.l4_src;
    dp = it.l4_dst;
    if (it.proto != PROTO_TCP && it.proto != PROTO_UDP) begin
      sp = '0;
      dp = '0;
    end
    for (int k = NRULE - 1; k >= 0; k--)
      if (rules[k].src == it.ip_src && rules[k].dst == it.ip_dst &&
          rules[k].sport == sp && rules[k].dport == dp && rules[k].proto == it.proto)
        tid = rules[k].owner;
    wid = ten_wrk[tid];
    if (it.time_slot == ten_slot[tid]) begin
      if (ten_cnt[tid] != ALL_ONES) ten_cnt[tid]++;
      if (ten_cnt[tid] > rate_limit) drop = 1'b1;
    end else begin
      ten_slot[tid] = it.time_slot;
      ten_cnt[tid] = 32'd1;
      if (it.time_slot != wrk_slot[wid]) begin
        wrk_slot[wid] = it.time_slot;
        wrk_prev[wid] = wrk_cur[wid];
        wrk_cur[wid] = '0;
      end
      if (wrk_prev[wid] >= capacity) begin
        best_load = ALL_ONES;
        min_q = '0;
        for (int k = 0; k < NWRK; k++)
          if (best_load > wrk_prev[k]) begin
            best_load = wrk_prev[k];
            min_q = 2'(k);
          end
        best_load = add_sat(best_load, ten_cnt[tid]);
        if (best_load < capacity) begin
          ten_wrk[tid] = min_q;
          wrk_prev[min_q] = best_load;
          wrk_prev[wid] = (wrk_prev[wid] >= ten_cnt[tid]) ? wrk_prev[wid] - ten_cnt[tid]
                                                          : '0;
        end
      end
    end
    if (wrk_cur[wid] != ALL_ONES) wrk_cur[wid]++;
    r.tenant = tid;
    r.worker = wid;
    r.dropped = drop;
    expected_results.push_back(r);
  endtask

  // sender: bursts with random gaps
  task automatic send_item(input tcrl_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_dispatch(it);
    if (it.kind == KIND_RULE) rules_sent++;
    else packets_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RATE_LIMIT) rate_limit = val;
    else capacity = val;
  endtask

  function automatic tcrl_in_t make_rule(int idx, logic [3:0] owner);
    tcrl_in_t it;
    it.kind = KIND_RULE;
    it.rule_index = 3'(idx);
    it.ip_src = 32'hc0a80000 | ($urandom & 32'h3);
    it.ip_dst = 32'h0a000000 | ($urandom & 32'h3);
    it.proto = ($urandom_range(0, 2) == 0) ? 8'd1 : (($urandom & 1) ? PROTO_TCP : PROTO_UDP);
    it.l4_src = (it.proto == 8'd1) ? 16'd0 : 16'($urandom_range(0, 3));
    it.l4_dst = (it.proto == 8'd1) ? 16'd0 : 16'($urandom_range(0, 3));
    it.rule_tenant = owner;
    it.time_slot = $urandom;
    return it;
  endfunction

  // packet that hits a rule most of the time, random otherwise
  function automatic tcrl_in_t make_packet(logic [31:0] ts);
    tcrl_in_t it;
    int k;
    k = $urandom_range(0, NRULE - 1);
    it = '0;
    it.kind = KIND_PACKET;
    it.rule_index = 3'($urandom);
    it.rule_tenant = 4'($urandom);
    it.time_slot = ts;
    if ($urandom_range(0, 9) < 7) begin
      it.ip_src = rules[k].src;
      it.ip_dst = rules[k].dst;
      it.proto = rules[k].proto;
      if (it.proto == PROTO_TCP || it.proto == PROTO_UDP) begin
        it.l4_src = rules[k].sport;
        it.l4_dst = rules[k].dport;
      end else begin
        it.l4_src = 16'($urandom);
        it.l4_dst = 16'($urandom);
      end
    end else begin
      it.ip_src = $urandom;
      it.ip_dst = $urandom;
      it.l4_src = 16'($urandom);
      it.l4_dst = 16'($urandom);
      it.proto = 8'($urandom);
    end
    return it;
  endfunction

  // receiver stall pattern and checker
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else case ($urandom_range(0, 9))
      0, 1, 2: out_ch.ready <= 1'b0;
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    tcrl_out_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.dropped) drops_seen++;
        if (out_ch.data.tenant !== exp_r.tenant) begin
          $display("%0t: tenant expected %0d actual %0d", $time, exp_r.tenant,
                   out_ch.data.tenant);
          errors++;
        end
        if (out_ch.data.worker !== exp_r.worker) begin
          $display("%0t: worker expected %0d actual %0d", $time, exp_r.worker,
                   out_ch.data.worker);
          errors++;
        end
        if (out_ch.data.dropped !== exp_r.dropped) begin
          $display("%0t: dropped expected %0d actual %0d", $time, exp_r.dropped,
                   out_ch.data.dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    tcrl_in_t it;
    // rule with all-ones fields, owner 15
    it = '0;
    it.kind = KIND_RULE;
    it.rule_index = 3'd7;
    it.ip_src = ALL_ONES;
    it.ip_dst = ALL_ONES;
    it.l4_src = 16'hffff;
    it.l4_dst = 16'hffff;
    it.proto = PROTO_TCP;
    it.rule_tenant = 4'hf;
    it.time_slot = ALL_ONES;
    send_item(it);
    it.kind = KIND_PACKET;
    it.rule_index = 3'd0;
    it.rule_tenant = 4'd0;
    send_item(it);
    send_item(it);
    // non tcp/udp: ports ignored, rule with zero ports matches
    it = '0;
    it.kind = KIND_RULE;
    it.rule_index = 3'd0;
    it.ip_src = 32'd1;
    it.proto = 8'hff;
    it.rule_tenant = 4'd9;
    send_item(it);
    it.kind = KIND_PACKET;
    it.l4_src = 16'hffff;
    it.l4_dst = 16'h1234;
    it.time_slot = 32'd3;
    send_item(it);
    // udp: no rule has this protocol, so this misses
    it.proto = PROTO_UDP;
    send_item(it);
    // all-zero packet hits the reset rules with owner 0
    it = '0;
    send_item(it);
    send_item(it);
  endtask

  task automatic test_rate_limit();
    tcrl_in_t it;
    write_cfg(CFG_RATE_LIMIT, 32'd0);
    it = '0;
    it.time_slot = 32'd100;
    repeat (3) send_item(it);
    write_cfg(CFG_RATE_LIMIT, 32'd2);
    it.time_slot = 32'd101;
    repeat (4) send_item(it);
    write_cfg(CFG_RATE_LIMIT, ALL_ONES);
    repeat (2) send_item(it);
  endtask

  task automatic test_rebalance();
    tcrl_in_t it;
    write_cfg(CFG_CAPACITY, 32'd0);
    it = '0;
    it.time_slot = 32'd200;
    send_item(it);
    write_cfg(CFG_CAPACITY, 32'd3);
    it.time_slot = 32'd201;
    repeat (5) send_item(it);
    it.time_slot = 32'd202;
    send_item(it);
    write_cfg(CFG_CAPACITY, ALL_ONES);
    send_item(it);
  endtask

  task automatic test_random();
    tcrl_in_t it;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_RATE_LIMIT, 32'd3); write_cfg(CFG_CAPACITY, 32'd6); end
        1: begin write_cfg(CFG_RATE_LIMIT, 32'd1); write_cfg(CFG_CAPACITY, 32'd2); end
        2: begin write_cfg(CFG_RATE_LIMIT, 32'd8); write_cfg(CFG_CAPACITY, 32'd20); end
        3: begin write_cfg(CFG_RATE_LIMIT, 32'd0); write_cfg(CFG_CAPACITY, 32'd1); end
        4: begin write_cfg(CFG_RATE_LIMIT, ALL_ONES); write_cfg(CFG_CAPACITY, ALL_ONES); end
        default: begin
          write_cfg(CFG_RATE_LIMIT, RATE_LIMIT_RST);
          write_cfg(CFG_CAPACITY, 32'($urandom_range(1, 12)));
        end
      endcase
      for (int n = 0; n < 285; n++) begin
        if ($urandom_range(0, 15) == 0) cur_slot += 32'($urandom_range(1, 2));
        if ($urandom_range(0, 199) == 0) cur_slot = $urandom;
        if ($urandom_range(0, 19) == 0)
          send_item(make_rule($urandom_range(0, NRULE - 1), 4'($urandom)));
        else send_item(make_packet(($urandom_range(0, 29) == 0) ? $urandom : cur_slot));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_rate_limit();
    test_rebalance();
    test_random();
    drain();
    $display("sent %0d packets and %0d rule writes, checked %0d results (%0d dropped)",
             packets_sent, rules_sent, results_seen, drops_seen);
    $display("covered rate limits and worker capacities from zero to all ones");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
